/* hw/rtl/csp_pkg.sv */
// csp_pkg: shared constants for the charge sharing subpixel position block
// default sizes, event type codes, configuration port widths, register indexes, register widths and reset values
// no dependencies
package csp_pkg;

  // default sizes
  localparam int COORD_BITS_DEF  = 10;
  localparam int HEIGHT_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF   = 8;

  // event type codes
  localparam logic [7:0] KIND_SINGLE_A = 8'd10;
  localparam logic [7:0] KIND_SINGLE_B = 8'd11;
  localparam logic [7:0] KIND_DOUBLE_A = 8'd20;
  localparam logic [7:0] KIND_DOUBLE_B = 8'd21;
  localparam logic [7:0] KIND_DOUBLE_H = 8'd22;

  // configuration port
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic [CFG_INDEX_BITS-1:0] REG_SPLIT_THRESHOLD   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SHARE_WIDTH       = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SHARE_GAIN        = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SINGLE_COL_OFFSET = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SINGLE_ROW_OFFSET = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DOUBLE_OFFSET     = 3'd5;

  localparam int THRESH_BITS = 12;
  localparam int WIDTH_BITS  = 16;
  localparam int GAIN_BITS   = 16;
  localparam int OFFSET_BITS = 9;

  localparam logic [THRESH_BITS-1:0] THRESH_RESET = 12'd0;
  localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 16'd16384;
  localparam logic [GAIN_BITS-1:0]   GAIN_RESET   = 16'd256;
  localparam logic [OFFSET_BITS-1:0] OFFSET_RESET = 9'd0;

endpackage

/* hw/rtl/charge_sharing_subpixel_position.sv */
// charge_sharing_subpixel_position: subpixel position of single and double events
// decode, pair select, sharing ratio multiply and a bit-serial divider pipeline
// depends on csp_pkg
//
// the divider resolves one quotient bit per stage
// throughput: one event per cycle; a stalled result freezes the whole pipeline
// reset: synchronous, clears all valid bits and loads the register reset values
module charge_sharing_subpixel_position #(
  parameter int COORD_BITS  = csp_pkg::COORD_BITS_DEF,
  parameter int HEIGHT_BITS = csp_pkg::HEIGHT_BITS_DEF,
  parameter int FRAC_BITS   = csp_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // configuration write channel
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [csp_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [csp_pkg::CFG_DATA_BITS-1:0]      cfg_data,
  // event channel
  input  logic                                   evt_valid,
  output logic                                   evt_stall,
  input  logic [COORD_BITS-1:0]                  pixel_row,
  input  logic [COORD_BITS-1:0]                  pixel_col,
  input  logic [7:0]                             event_kind,
  input  logic signed [HEIGHT_BITS-1:0]          centre_height,
  input  logic signed [HEIGHT_BITS-1:0]          left_height,
  input  logic signed [HEIGHT_BITS-1:0]          below_height,
  input  logic signed [HEIGHT_BITS-1:0]          right_height,
  input  logic signed [HEIGHT_BITS-1:0]          above_height,
  input  logic [15:0]                            merged_height,
  // result channel
  output logic                                   res_valid,
  input  logic                                   res_stall,
  output logic signed [COORD_BITS+FRAC_BITS:0]   sub_col,
  output logic signed [COORD_BITS+FRAC_BITS:0]   sub_row,
  output logic [7:0]                             out_kind,
  output logic [15:0]                            out_height
);
  import csp_pkg::*;

  localparam int HB  = HEIGHT_BITS;
  localparam int OB  = COORD_BITS + FRAC_BITS + 1;   // output width
  localparam int BW  = COORD_BITS + FRAC_BITS + 2;   // base coordinate width
  localparam int QB  = COORD_BITS + FRAC_BITS + 2;   // kept quotient width
  localparam int SW  = COORD_BITS + FRAC_BITS + 4;   // final sum width
  localparam int OFW = FRAC_BITS + 2;                // scaled offset width
  localparam int MW  = 32 + HB;                      // product width
  localparam int SH  = 25 - FRAC_BITS;               // divisor scale
  localparam int NWA = 34 + HB;
  localparam int NWB = SH + QB + 1;
  localparam int NW  = (NWA > NWB) ? NWA : NWB;      // rounded numerator width
  localparam int QN  = NW - SH;                      // quotient bits computed
  localparam int TW  = (HB > THRESH_BITS) ? HB : THRESH_BITS;
  localparam int LS  = (FRAC_BITS >= 8) ? FRAC_BITS - 8 : 0;
  localparam int RS  = (FRAC_BITS < 8) ? 8 - FRAC_BITS : 0;
  localparam int EW  = OFFSET_BITS + LS + 1;
  localparam logic [EW-1:0] RND = EW'((1 << RS) >> 1);
  localparam logic signed [BW-1:0] HALF = BW'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [SW-1:0] SAT_HI = (SW'(1) <<< (OB - 1)) - SW'(1);
  localparam logic signed [SW-1:0] SAT_LO = -(SW'(1) <<< (OB - 1));

  localparam logic [1:0] SEL_LEFT  = 2'd0;
  localparam logic [1:0] SEL_RIGHT = 2'd1;
  localparam logic [1:0] SEL_BELOW = 2'd2;
  localparam logic [1:0] SEL_ABOVE = 2'd3;

  typedef struct packed {
    logic                 shc;
    logic                 shr;
    logic                 neg;
    logic signed [BW-1:0] base_col;
    logic signed [BW-1:0] base_row;
    logic [7:0]           kind;
    logic [15:0]          height;
  } side_t;

  // 1/256 offset register to 2^-FRAC_BITS units, ties away from zero
  function automatic logic signed [OFW-1:0] off_scale(input logic signed [OFFSET_BITS-1:0] o);
    logic [OFFSET_BITS-1:0] mag;
    logic [EW-1:0]          tmp;
    logic [OFW-1:0]         res;
    mag = o[OFFSET_BITS-1] ? OFFSET_BITS'(-o) : o;
    tmp = ((EW'(mag) << LS) + RND) >> RS;
    res = tmp[OFW-1:0];
    return o[OFFSET_BITS-1] ? -signed'(res) : signed'(res);
  endfunction

  // ---------------- configuration registers ----------------
  logic [THRESH_BITS-1:0] thr_reg;
  logic [WIDTH_BITS-1:0]  width_reg;
  logic [GAIN_BITS-1:0]   gain_reg;
  logic [OFFSET_BITS-1:0] offc_reg;
  logic [OFFSET_BITS-1:0] offr_reg;
  logic [OFFSET_BITS-1:0] offd_reg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr_reg   <= THRESH_RESET;
      width_reg <= WIDTH_RESET;
      gain_reg  <= GAIN_RESET;
      offc_reg  <= OFFSET_RESET;
      offr_reg  <= OFFSET_RESET;
      offd_reg  <= OFFSET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SPLIT_THRESHOLD:   thr_reg   <= cfg_data[THRESH_BITS-1:0];
        REG_SHARE_WIDTH:       width_reg <= cfg_data[WIDTH_BITS-1:0];
        REG_SHARE_GAIN:        gain_reg  <= cfg_data[GAIN_BITS-1:0];
        REG_SINGLE_COL_OFFSET: offc_reg  <= cfg_data[OFFSET_BITS-1:0];
        REG_SINGLE_ROW_OFFSET: offr_reg  <= cfg_data[OFFSET_BITS-1:0];
        REG_DOUBLE_OFFSET:     offd_reg  <= cfg_data[OFFSET_BITS-1:0];
        default: ;
      endcase
    end
  end

  // derived constants, refreshed every cycle from the registers
  logic [31:0]           wg;
  logic signed [OFW-1:0] offc;
  logic signed [OFW-1:0] offr;
  logic signed [OFW-1:0] offd;
  logic signed [HB-1:0]  thr;
  logic [TW-1:0]         thr_ext;

  assign thr_ext = TW'(thr_reg);

  always_ff @(posedge clk) begin
    wg   <= 32'(width_reg) * 32'(gain_reg);
    offc <= off_scale(signed'(offc_reg));
    offr <= off_scale(signed'(offr_reg));
    offd <= off_scale(signed'(offd_reg));
    thr  <= signed'(thr_ext[HB-1:0]);
  end

  // ---------------- pipeline control ----------------
  logic adv;
  assign adv       = !(res_valid && res_stall);
  assign evt_stall = !adv;

  // ---------------- stage 1: input capture ----------------
  logic                  p1_valid;
  logic [COORD_BITS-1:0] p1_row;
  logic [COORD_BITS-1:0] p1_col;
  logic [7:0]            p1_kind;
  logic signed [HB-1:0]  p1_c;
  logic signed [HB-1:0]  p1_l;
  logic signed [HB-1:0]  p1_b;
  logic signed [HB-1:0]  p1_r;
  logic signed [HB-1:0]  p1_a;
  logic [15:0]           p1_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (adv) begin
      p1_valid <= evt_valid;
    end
    if (adv) begin
      p1_row    <= pixel_row;
      p1_col    <= pixel_col;
      p1_kind   <= event_kind;
      p1_c      <= centre_height;
      p1_l      <= left_height;
      p1_b      <= below_height;
      p1_r      <= right_height;
      p1_a      <= above_height;
      p1_height <= merged_height;
    end
  end

  // decode and neighbour search
  logic                 s1_single;
  logic                 s1_double;
  logic                 s1_found;
  logic [1:0]           s1_sel;
  logic signed [HB-1:0] s1_n;

  always_comb begin
    s1_single = (p1_kind == KIND_SINGLE_A) || (p1_kind == KIND_SINGLE_B);
    s1_double = (p1_kind == KIND_DOUBLE_A) || (p1_kind == KIND_DOUBLE_B);
    s1_found  = 1'b1;
    s1_sel    = SEL_LEFT;
    s1_n      = p1_l;
    if (p1_l >= thr) begin
      s1_sel = SEL_LEFT;
      s1_n   = p1_l;
    end else if (p1_r >= thr) begin
      s1_sel = SEL_RIGHT;
      s1_n   = p1_r;
    end else if (p1_b >= thr) begin
      s1_sel = SEL_BELOW;
      s1_n   = p1_b;
    end else if (p1_a >= thr) begin
      s1_sel = SEL_ABOVE;
      s1_n   = p1_a;
    end else begin
      s1_found = 1'b0;
    end
  end

  // ---------------- stage 2: chosen pair ----------------
  logic                  p2_valid;
  logic                  p2_single;
  logic [1:0]            p2_sel;
  logic signed [HB-1:0]  p2_c;
  logic signed [HB-1:0]  p2_n;
  logic [COORD_BITS-1:0] p2_row;
  logic [COORD_BITS-1:0] p2_col;
  logic [7:0]            p2_kind;
  logic [15:0]           p2_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else if (adv) begin
      p2_valid <= p1_valid && (s1_single || (s1_double && s1_found));
    end
    if (adv) begin
      p2_single <= s1_single;
      p2_sel    <= s1_sel;
      p2_c      <= p1_c;
      p2_n      <= s1_n;
      p2_row    <= p1_row;
      p2_col    <= p1_col;
      p2_kind   <= p1_kind;
      p2_height <= p1_height;
    end
  end

  // ratio operands and base coordinates
  logic                 s2_horiz;
  logic signed [HB:0]   s2_a;
  logic signed [HB:0]   s2_b;
  logic signed [HB:0]   s2_diff;
  logic signed [HB:0]   s2_sum;
  logic [HB:0]          s2_mag;
  logic signed [BW-1:0] s2_colf;
  logic signed [BW-1:0] s2_rowf;
  side_t                s2_side;

  always_comb begin
    s2_horiz = (p2_sel == SEL_LEFT) || (p2_sel == SEL_RIGHT);
    // neighbour comes first for left and below
    if ((p2_sel == SEL_LEFT) || (p2_sel == SEL_BELOW)) begin
      s2_a = (HB+1)'(p2_n);
      s2_b = (HB+1)'(p2_c);
    end else begin
      s2_a = (HB+1)'(p2_c);
      s2_b = (HB+1)'(p2_n);
    end
    s2_diff = s2_a - s2_b;
    s2_sum  = s2_a + s2_b;
    s2_mag  = s2_diff[HB] ? (HB+1)'(-s2_diff) : s2_diff;
    s2_colf = signed'(BW'({p2_col, {FRAC_BITS{1'b0}}}));
    s2_rowf = signed'(BW'({p2_row, {FRAC_BITS{1'b0}}}));

    s2_side.shc    = !p2_single && s2_horiz;
    s2_side.shr    = !p2_single && !s2_horiz;
    s2_side.neg    = s2_diff[HB];
    s2_side.height = p2_height;
    if (p2_single) begin
      s2_side.base_col = s2_colf + BW'(offc);
      s2_side.base_row = s2_rowf + BW'(offr);
      s2_side.kind     = p2_kind;
    end else if (s2_horiz) begin
      s2_side.base_col = (p2_sel == SEL_LEFT) ? s2_colf - HALF : s2_colf + HALF;
      s2_side.base_row = s2_rowf + BW'(offd);
      s2_side.kind     = KIND_DOUBLE_H;
    end else begin
      s2_side.base_col = s2_colf + BW'(offd);
      s2_side.base_row = (p2_sel == SEL_BELOW) ? s2_rowf - HALF : s2_rowf + HALF;
      s2_side.kind     = p2_kind;
    end
  end

  // ---------------- stage 3: operands registered ----------------
  logic          p3_valid;
  logic [HB-1:0] p3_mag;
  logic [HB-1:0] p3_sum;
  side_t         p3_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_valid <= 1'b0;
    end else if (adv) begin
      // a double with a non-positive pair sum is dropped
      p3_valid <= p2_valid && (p2_single || (!s2_sum[HB] && (s2_sum != '0)));
    end
    if (adv) begin
      p3_mag  <= s2_mag[HB-1:0];
      p3_sum  <= s2_sum[HB-1:0];
      p3_side <= s2_side;
    end
  end

  // ---------------- stage 4: width * gain * |a-b| ----------------
  logic          p4_valid;
  logic [MW-1:0] p4_num;
  logic [HB-1:0] p4_sum;
  side_t         p4_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      p4_valid <= 1'b0;
    end else if (adv) begin
      p4_valid <= p3_valid;
    end
    if (adv) begin
      p4_num  <= MW'(wg) * MW'(p3_mag);
      p4_sum  <= p3_sum;
      p4_side <= p3_side;
    end
  end

  // round to nearest: (2*num + den) / (2*den), low SH bits of 2*den are zero
  logic [NW-1:0] s4_nbig;
  assign s4_nbig = (NW'(p4_num) << 1) + (NW'(p4_sum) << (24 - FRAC_BITS));

  // ---------------- divider: one quotient bit per stage ----------------
  logic          dv_valid [0:QN];
  logic [QN-1:0] dv_nh    [0:QN];
  logic [HB-1:0] dv_rem   [0:QN];
  logic [QN-1:0] dv_q     [0:QN];
  logic [HB-1:0] dv_sum   [0:QN];
  side_t         dv_side  [0:QN];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid[0] <= 1'b0;
    end else if (adv) begin
      dv_valid[0] <= p4_valid;
    end
    if (adv) begin
      dv_nh[0]   <= s4_nbig[NW-1:SH];
      dv_rem[0]  <= '0;
      dv_q[0]    <= '0;
      dv_sum[0]  <= p4_sum;
      dv_side[0] <= p4_side;
    end
  end

  for (genvar k = 1; k <= QN; k++) begin : g_div
    logic [HB:0] trial;
    logic        take;
    logic [HB:0] rem_new;

    assign trial   = {dv_rem[k-1], dv_nh[k-1][QN-1]};
    assign take    = trial >= {1'b0, dv_sum[k-1]};
    assign rem_new = take ? trial - {1'b0, dv_sum[k-1]} : trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[k] <= 1'b0;
      end else if (adv) begin
        dv_valid[k] <= dv_valid[k-1];
      end
      if (adv) begin
        dv_nh[k]   <= dv_nh[k-1] << 1;
        dv_rem[k]  <= rem_new[HB-1:0];
        dv_q[k]    <= {dv_q[k-1][QN-2:0], take};
        dv_sum[k]  <= dv_sum[k-1];
        dv_side[k] <= dv_side[k-1];
      end
    end
  end

  // ---------------- final: apply sharing term and saturate ----------------
  side_t                fin_side;
  logic [QN-1:0]        fin_q;
  logic [QB-1:0]        fin_qs;
  logic signed [SW-1:0] fin_term;
  logic signed [SW-1:0] fin_col;
  logic signed [SW-1:0] fin_row;
  logic signed [OB-1:0] fin_col_sat;
  logic signed [OB-1:0] fin_row_sat;

  always_comb begin
    fin_side = dv_side[QN];
    fin_q    = dv_q[QN];
    // any quotient this large saturates the coordinate anyway
    fin_qs   = (fin_q[QN-1:QB] != '0) ? '1 : fin_q[QB-1:0];
    fin_term = fin_side.neg ? signed'(SW'(fin_qs)) : -signed'(SW'(fin_qs));
    fin_col  = SW'(fin_side.base_col) + (fin_side.shc ? fin_term : '0);
    fin_row  = SW'(fin_side.base_row) + (fin_side.shr ? fin_term : '0);
    if (fin_col > SAT_HI) begin
      fin_col_sat = SAT_HI[OB-1:0];
    end else if (fin_col < SAT_LO) begin
      fin_col_sat = SAT_LO[OB-1:0];
    end else begin
      fin_col_sat = fin_col[OB-1:0];
    end
    if (fin_row > SAT_HI) begin
      fin_row_sat = SAT_HI[OB-1:0];
    end else if (fin_row < SAT_LO) begin
      fin_row_sat = SAT_LO[OB-1:0];
    end else begin
      fin_row_sat = fin_row[OB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= dv_valid[QN];
    end
    if (adv) begin
      sub_col    <= fin_col_sat;
      sub_row    <= fin_row_sat;
      out_kind   <= fin_side.kind;
      out_height <= fin_side.height;
    end
  end

endmodule

/* hw/rtl/csp_checker.sv */
// csp_checker: port-level assertions for charge_sharing_subpixel_position
// attached to the top level by the bind statement at the end of this file
// depends on csp_pkg
module csp_checker #(
  parameter int COORD_BITS  = csp_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS   = csp_pkg::FRAC_BITS_DEF
) (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 evt_stall,
  input logic                                 res_valid,
  input logic                                 res_stall,
  input logic signed [COORD_BITS+FRAC_BITS:0] sub_col,
  input logic signed [COORD_BITS+FRAC_BITS:0] sub_row,
  input logic [7:0]                           out_kind,
  input logic [15:0]                          out_height
);
  import csp_pkg::*;

  // a stalled result transaction holds its payload
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(sub_col) && $stable(sub_row)
      && $stable(out_kind) && $stable(out_height))
    else $error("stalled result changed");

  // the event side only stalls behind a stalled result
  a_stall_cause: assert property (@(posedge clk)
    evt_stall |-> res_valid && res_stall)
    else $error("event stall without stalled result");

  // only single, vertical double or retyped horizontal double codes come out
  a_kind_out: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (out_kind == KIND_SINGLE_A) || (out_kind == KIND_SINGLE_B)
      || (out_kind == KIND_DOUBLE_A) || (out_kind == KIND_DOUBLE_B)
      || (out_kind == KIND_DOUBLE_H))
    else $error("unexpected result kind");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

endmodule

bind charge_sharing_subpixel_position csp_checker #(
  .COORD_BITS (COORD_BITS),
  .FRAC_BITS  (FRAC_BITS)
) u_csp_checker (.*);

/* dv/charge_sharing_subpixel_position_tb.sv */
// charge_sharing_subpixel_position_tb: self-checking bench for the subpixel position block
// directed single, double and dropped events, register extremes, then bursty random traffic
// depends on csp_pkg and charge_sharing_subpixel_position
module charge_sharing_subpixel_position_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import csp_pkg::*;

  localparam int CW = COORD_BITS_DEF;
  localparam int HW = HEIGHT_BITS_DEF;
  localparam int FW = FRAC_BITS_DEF;
  localparam int OW = CW + FW + 1;
  localparam int HMIN = -(1 << (HW - 1));
  localparam int HMAX = (1 << (HW - 1)) - 1;
  localparam longint ONE_PIXEL = longint'(1) << FW;
  localparam longint HALF_PIXEL = ONE_PIXEL / 2;
  localparam longint OUT_MAX = (longint'(1) << (OW - 1)) - 1;
  localparam longint OUT_MIN = -(longint'(1) << (OW - 1));
  localparam longint OFFSET_UNIT = 256;
  // width q0.16 times gain q8.8 carries 24 fraction bits
  localparam int SHARE_SHIFT = 24 - FW;
  localparam int DRAIN_CYCLES = HW + FW + 14 + 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_EVENTS = 92;

  localparam logic [7:0] KIND_NONE = 8'd0;
  localparam logic [7:0] KIND_UNUSED = 8'd12;
  localparam logic [7:0] KIND_TOP = 8'd255;
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNMAPPED_LO = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNMAPPED_HI = 3'd7;

  typedef longint unsigned u64_t;

  typedef enum logic [1:0] {
    STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC
  } stall_mode_t;

  typedef struct packed {
    logic [CW-1:0]        pixel_row;
    logic [CW-1:0]        pixel_col;
    logic [7:0]           event_kind;
    logic signed [HW-1:0] centre_height;
    logic signed [HW-1:0] left_height;
    logic signed [HW-1:0] below_height;
    logic signed [HW-1:0] right_height;
    logic signed [HW-1:0] above_height;
    logic [15:0]          merged_height;
  } evt_item_t;

  typedef struct packed {
    logic signed [OW-1:0] sub_col;
    logic signed [OW-1:0] sub_row;
    logic [7:0]           out_kind;
    logic [15:0]          out_height;
  } res_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic evt_valid = 1'b0;
  logic evt_stall;
  logic [CW-1:0] pixel_row = '0;
  logic [CW-1:0] pixel_col = '0;
  logic [7:0] event_kind = '0;
  logic signed [HW-1:0] centre_height = '0;
  logic signed [HW-1:0] left_height = '0;
  logic signed [HW-1:0] below_height = '0;
  logic signed [HW-1:0] right_height = '0;
  logic signed [HW-1:0] above_height = '0;
  logic [15:0] merged_height = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  logic signed [OW-1:0] sub_col;
  logic signed [OW-1:0] sub_row;
  logic [7:0] out_kind;
  logic [15:0] out_height;

  // register image kept alongside the block
  logic signed [THRESH_BITS-1:0] cfg_thresh = THRESH_RESET;
  logic [WIDTH_BITS-1:0] cfg_width = WIDTH_RESET;
  logic [GAIN_BITS-1:0] cfg_gain = GAIN_RESET;
  logic signed [OFFSET_BITS-1:0] cfg_col_off = OFFSET_RESET;
  logic signed [OFFSET_BITS-1:0] cfg_row_off = OFFSET_RESET;
  logic signed [OFFSET_BITS-1:0] cfg_dbl_off = OFFSET_RESET;

  res_item_t predicted_positions[$];
  int errors = 0;
  int quiet_cycles = 0;
  int burst_left = 0;
  logic stall_on = 1'b0;
  stall_mode_t stall_mode = STALL_NONE;
  int stall_left = 0;

  charge_sharing_subpixel_position dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .evt_valid    (evt_valid),
    .evt_stall    (evt_stall),
    .pixel_row    (pixel_row),
    .pixel_col    (pixel_col),
    .event_kind   (event_kind),
    .centre_height(centre_height),
    .left_height  (left_height),
    .below_height (below_height),
    .right_height (right_height),
    .above_height (above_height),
    .merged_height(merged_height),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .sub_col      (sub_col),
    .sub_row      (sub_row),
    .out_kind     (out_kind),
    .out_height   (out_height)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------- position predictor

  function automatic longint round_div(input longint num, input u64_t den);
    u64_t mag;
    u64_t q;
    mag = (num < 0) ? u64_t'(-num) : u64_t'(num);
    q = (2 * mag + den) / (2 * den);
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint offset_frac(input logic signed [OFFSET_BITS-1:0] off);
    return round_div(longint'(off) * ONE_PIXEL, u64_t'(OFFSET_UNIT));
  endfunction

  // width * gain * (a-b)/(a+b), caller guarantees a+b > 0
  function automatic longint share_term(input longint a, input longint b);
    longint diff;
    u64_t mag;
    u64_t num;
    u64_t den;
    u64_t q;
    diff = a - b;
    mag = (diff < 0) ? u64_t'(-diff) : u64_t'(diff);
    num = u64_t'(cfg_width) * u64_t'(cfg_gain) * mag;
    den = u64_t'(a + b) << SHARE_SHIFT;
    q = (2 * num + den) / (2 * den);
    return (diff < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [OW-1:0] saturate(input longint v);
    if (v > OUT_MAX) return OUT_MAX[OW-1:0];
    if (v < OUT_MIN) return OUT_MIN[OW-1:0];
    return v[OW-1:0];
  endfunction

  function automatic bit predict_position(input evt_item_t ev, output res_item_t res);
    longint row, col, c, l, b, r, a, th, d, scol, srow;
    logic [7:0] okind;
    res = '0;
    row = longint'(ev.pixel_row) * ONE_PIXEL;
    col = longint'(ev.pixel_col) * ONE_PIXEL;
    c = longint'(signed'(ev.centre_height));
    l = longint'(signed'(ev.left_height));
    b = longint'(signed'(ev.below_height));
    r = longint'(signed'(ev.right_height));
    a = longint'(signed'(ev.above_height));
    th = longint'(cfg_thresh);
    okind = ev.event_kind;
    if (ev.event_kind == KIND_SINGLE_A || ev.event_kind == KIND_SINGLE_B) begin
      scol = col + offset_frac(cfg_col_off);
      srow = row + offset_frac(cfg_row_off);
    end else if (ev.event_kind == KIND_DOUBLE_A || ev.event_kind == KIND_DOUBLE_B) begin
      d = offset_frac(cfg_dbl_off);
      // first neighbour at or over threshold wins, a bad sum drops without trying the rest
      if (l >= th) begin
        if (l + c <= 0) return 1'b0;
        scol = col - HALF_PIXEL - share_term(l, c);
        srow = row + d;
        okind = KIND_DOUBLE_H;
      end else if (r >= th) begin
        if (c + r <= 0) return 1'b0;
        scol = col + HALF_PIXEL - share_term(c, r);
        srow = row + d;
        okind = KIND_DOUBLE_H;
      end else if (b >= th) begin
        if (b + c <= 0) return 1'b0;
        scol = col + d;
        srow = row - HALF_PIXEL - share_term(b, c);
      end else if (a >= th) begin
        if (c + a <= 0) return 1'b0;
        scol = col + d;
        srow = row + HALF_PIXEL - share_term(c, a);
      end else begin
        return 1'b0;
      end
    end else begin
      return 1'b0;
    end
    res.sub_col = saturate(scol);
    res.sub_row = saturate(srow);
    res.out_kind = okind;
    res.out_height = ev.merged_height;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- monitor and checker

  always @(posedge clk) begin
    evt_item_t seen;
    res_item_t want;
    if (!rst) begin
      if (res_valid && !res_stall) begin
        if (predicted_positions.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10)
            $display("unexpected result: col %0d row %0d kind %0d height %0d",
                     sub_col, sub_row, out_kind, out_height);
        end else begin
          want = predicted_positions.pop_front();
          if (want.sub_col !== sub_col || want.sub_row !== sub_row ||
              want.out_kind !== out_kind || want.out_height !== out_height) begin
            errors <= errors + 1;
            if (errors < 10)
              $display("mismatch: expected col %0d row %0d kind %0d height %0d, got %0d %0d %0d %0d",
                       want.sub_col, want.sub_row, want.out_kind, want.out_height,
                       sub_col, sub_row, out_kind, out_height);
          end
        end
      end
      if (evt_valid && !evt_stall) begin
        seen.pixel_row = pixel_row;
        seen.pixel_col = pixel_col;
        seen.event_kind = event_kind;
        seen.centre_height = centre_height;
        seen.left_height = left_height;
        seen.below_height = below_height;
        seen.right_height = right_height;
        seen.above_height = above_height;
        seen.merged_height = merged_height;
        if (predict_position(seen, want)) predicted_positions.push_back(want);
      end
    end
  end

  // receiver backpressure in a random mode, picked anew each time its countdown runs out
  always @(posedge clk) begin
    if (rst || !stall_on) begin
      res_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode <= stall_mode_t'($urandom_range(3));
        stall_left <= $urandom_range(20, 120);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        STALL_LIGHT:    res_stall <= ($urandom_range(3) == 0);
        STALL_HEAVY:    res_stall <= ($urandom_range(1) == 0);
        STALL_PERIODIC: res_stall <= stall_left[1];
        default:        res_stall <= 1'b0;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (evt_valid && !evt_stall) || (res_valid && !res_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("charge_sharing_subpixel_position verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- drivers

  task automatic send_event(input evt_item_t ev);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        evt_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    pixel_row <= ev.pixel_row;
    pixel_col <= ev.pixel_col;
    event_kind <= ev.event_kind;
    centre_height <= ev.centre_height;
    left_height <= ev.left_height;
    below_height <= ev.below_height;
    right_height <= ev.right_height;
    above_height <= ev.above_height;
    merged_height <= ev.merged_height;
    evt_valid <= 1'b1;
    do @(posedge clk); while (evt_stall);
  endtask

  // stop sending, let every result out and the pipeline run dry
  task automatic wait_idle();
    evt_valid <= 1'b0;
    burst_left = 0;
    while (predicted_positions.size() != 0) @(posedge clk);
    stall_on <= 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    stall_on <= 1'b1;
  endtask

  task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                input logic [CFG_DATA_BITS-1:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_SPLIT_THRESHOLD:   cfg_thresh = data[THRESH_BITS-1:0];
      REG_SHARE_WIDTH:       cfg_width = data[WIDTH_BITS-1:0];
      REG_SHARE_GAIN:        cfg_gain = data[GAIN_BITS-1:0];
      REG_SINGLE_COL_OFFSET: cfg_col_off = data[OFFSET_BITS-1:0];
      REG_SINGLE_ROW_OFFSET: cfg_row_off = data[OFFSET_BITS-1:0];
      REG_DOUBLE_OFFSET:     cfg_dbl_off = data[OFFSET_BITS-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // narrow registers get random junk in the unused upper data bits
  task automatic set_registers(input int th,
                               input int width,
                               input int gain,
                               input int col_off,
                               input int row_off,
                               input int dbl_off);
    logic [CFG_DATA_BITS-1:0] pad;
    pad = CFG_DATA_BITS'($urandom);
    write_register(REG_SPLIT_THRESHOLD,
                   {pad[CFG_DATA_BITS-1:THRESH_BITS], th[THRESH_BITS-1:0]});
    write_register(REG_SHARE_WIDTH, width[WIDTH_BITS-1:0]);
    write_register(REG_SHARE_GAIN, gain[GAIN_BITS-1:0]);
    pad = CFG_DATA_BITS'($urandom);
    write_register(REG_SINGLE_COL_OFFSET,
                   {pad[CFG_DATA_BITS-1:OFFSET_BITS], col_off[OFFSET_BITS-1:0]});
    pad = CFG_DATA_BITS'($urandom);
    write_register(REG_SINGLE_ROW_OFFSET,
                   {pad[CFG_DATA_BITS-1:OFFSET_BITS], row_off[OFFSET_BITS-1:0]});
    pad = CFG_DATA_BITS'($urandom);
    write_register(REG_DOUBLE_OFFSET,
                   {pad[CFG_DATA_BITS-1:OFFSET_BITS], dbl_off[OFFSET_BITS-1:0]});
  endtask

  // ---------------------------------------------------------------- event builders

  function automatic evt_item_t make_event(input int row, input int col, input logic [7:0] kind,
                                           input int c, input int l, input int b,
                                           input int r, input int a, input int merged);
    evt_item_t ev;
    ev.pixel_row = row[CW-1:0];
    ev.pixel_col = col[CW-1:0];
    ev.event_kind = kind;
    ev.centre_height = c[HW-1:0];
    ev.left_height = l[HW-1:0];
    ev.below_height = b[HW-1:0];
    ev.right_height = r[HW-1:0];
    ev.above_height = a[HW-1:0];
    ev.merged_height = merged[15:0];
    return ev;
  endfunction

  function automatic int height_in(input int lo, input int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic int pick_coord();
    case ($urandom_range(9))
      0: return 0;
      1: return (1 << CW) - 1;
      default: return int'($urandom_range((1 << CW) - 1));
    endcase
  endfunction

  // mostly well-formed doubles around the current threshold, some singles and noise
  function automatic evt_item_t random_event();
    int h[4];
    int th, sel, win, k, c, lo;
    logic [7:0] kind;
    th = int'(cfg_thresh);
    sel = $urandom_range(99);
    for (k = 0; k < 4; k++) h[k] = height_in(HMIN, HMAX);
    c = height_in(HMIN, HMAX);
    if (sel < 22) begin
      kind = ($urandom_range(1) == 0) ? KIND_SINGLE_A : KIND_SINGLE_B;
    end else if (sel < 86) begin
      kind = ($urandom_range(1) == 0) ? KIND_DOUBLE_A : KIND_DOUBLE_B;
      // neighbour order is left, right, below, above
      win = $urandom_range(3);
      for (k = 0; k < win; k++)
        if (th > HMIN) h[k] = height_in(HMIN, th - 1);
      h[win] = height_in(th, HMAX);
      lo = 1 - h[win];
      if (lo < HMIN) lo = HMIN;
      if ($urandom_range(9) != 0 && lo <= HMAX) c = height_in(lo, HMAX);
    end else if (sel < 93) begin
      kind = ($urandom_range(1) == 0) ? KIND_DOUBLE_A : KIND_DOUBLE_B;
      for (k = 0; k < 4; k++)
        if (th > HMIN) h[k] = height_in(HMIN, th - 1);
    end else begin
      kind = 8'($urandom_range(255));
    end
    return make_event(pick_coord(), pick_coord(), kind, c, h[0], h[2], h[1], h[3],
                      int'($urandom_range('hFFFF)));
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_single_events();
    send_event(make_event(0, 0, KIND_SINGLE_A, HMAX, HMIN, HMAX, HMIN, HMAX, 0));
    send_event(make_event(1023, 1023, KIND_SINGLE_B, HMIN, HMAX, HMIN, HMAX, HMIN, 'hFFFF));
    send_event(make_event(1023, 0, KIND_SINGLE_A, 0, 0, 0, 0, 0, 'h5A5A));
    send_event(make_event(0, 1023, KIND_SINGLE_B, 1, -1, 1, -1, 1, 'hA5A5));
  endtask

  task automatic test_double_events();
    send_event(make_event(500, 600, KIND_DOUBLE_A, 300, 100, -5, -5, -5, 1234));
    send_event(make_event(10, 20, KIND_DOUBLE_B, 200, -1, 900, 500, 0, 77));
    send_event(make_event(1023, 1023, KIND_DOUBLE_A, 800, -1, 400, -1, HMAX, 9));
    // neighbour exactly at threshold
    send_event(make_event(0, 0, KIND_DOUBLE_B, 50, HMIN, HMIN, HMIN, 0, 'hFFFF));
    // sum of one gives the largest ratio
    send_event(make_event(512, 512, KIND_DOUBLE_A, HMIN + 2, HMAX, 0, 0, 0, 1));
    send_event(make_event(1, 1, KIND_DOUBLE_B, HMAX, HMAX, HMAX, HMAX, HMAX, 2));
  endtask

  task automatic test_dropped_events();
    send_event(make_event(3, 4, KIND_NONE, 100, 100, 100, 100, 100, 5));
    send_event(make_event(3, 4, KIND_UNUSED, 100, 100, 100, 100, 100, 6));
    send_event(make_event(3, 4, KIND_DOUBLE_H, 100, 100, 100, 100, 100, 7));
    send_event(make_event(3, 4, KIND_TOP, 100, 100, 100, 100, 100, 8));
    // no neighbour reaches the threshold
    send_event(make_event(8, 8, KIND_DOUBLE_A, 500, -1, -1, -1, -1, 9));
    // left chosen with zero sum, right would have been fine
    send_event(make_event(8, 8, KIND_DOUBLE_A, -5, 5, 0, 900, 0, 10));
    // below chosen with negative sum, above is not tried
    send_event(make_event(8, 8, KIND_DOUBLE_B, HMIN, -1, 100, -1, HMAX, 11));
    send_event(make_event(9, 9, KIND_DOUBLE_B, 0, 0, HMIN, HMIN, HMIN, 12));
  endtask

  task automatic test_register_extremes();
    wait_idle();
    set_registers(HMIN, 'hFFFF, 'hFFFF, 255, -256, -256);
    send_event(make_event(1023, 1023, KIND_SINGLE_A, 0, 0, 0, 0, 0, 1));
    send_event(make_event(0, 0, KIND_SINGLE_B, 0, 0, 0, 0, 0, 2));
    // saturation on both sides of the column range
    send_event(make_event(0, 0, KIND_DOUBLE_A, HMIN + 2, HMAX, 0, 0, 0, 3));
    send_event(make_event(1023, 1023, KIND_DOUBLE_B, HMAX, HMIN + 2, 0, 0, 0, 4));
    send_event(make_event(1023, 1023, KIND_DOUBLE_B, HMAX, HMIN, 0, 0, 0, 5));
    wait_idle();
    set_registers(HMAX, 0, 0, -256, 255, 255);
    write_register(REG_UNMAPPED_LO, CFG_DATA_BITS'($urandom));
    write_register(REG_UNMAPPED_HI, CFG_DATA_BITS'($urandom));
    send_event(make_event(0, 0, KIND_SINGLE_A, 0, 0, 0, 0, 0, 6));
    send_event(make_event(5, 5, KIND_DOUBLE_A, 100, HMAX - 1, 0, HMAX, 0, 7));
    send_event(make_event(7, 9, KIND_DOUBLE_B, HMAX - 1, HMAX - 1, HMAX - 1, HMAX - 1,
                          HMAX - 1, 8));
  endtask

  task automatic test_random_traffic();
    int phase, n, th;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_idle();
      case (phase)
        0: set_registers(int'(THRESH_RESET), int'(WIDTH_RESET), int'(GAIN_RESET), 0, 0, 0);
        1: set_registers(HMIN, 'hFFFF, 'hFFFF, -256, 255, -256);
        2: set_registers(HMAX, 0, 0, 255, -256, 255);
        default: begin
          th = ($urandom_range(1) == 0) ? height_in(-100, 600) : height_in(HMIN, HMAX);
          set_registers(th, $urandom,
                        ($urandom_range(1) == 0) ? $urandom_range(128, 1024) : $urandom,
                        height_in(-256, 255), height_in(-256, 255), height_in(-256, 255));
        end
      endcase
      for (n = 0; n < PHASE_EVENTS; n++) send_event(random_event());
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    stall_on <= 1'b1;
    @(posedge clk);
    test_single_events();
    test_double_events();
    test_dropped_events();
    test_register_extremes();
    test_random_traffic();
    wait_idle();
    if (errors == 0) begin
      $display("charge_sharing_subpixel_position verification clean");
    end else begin
      $display("charge_sharing_subpixel_position verification failed");
    end
    $finish;
  end

endmodule
